// ===== rtl/core/lrf_pkg.sv =====
// Shared constants and types for the largest-region-after-one-fill block
package lrf_pkg;
    localparam int MAX_SIDE    = 32;
    localparam int SIDE_W      = $clog2(MAX_SIDE);
    localparam int CFG_W       = 6;
    localparam int ADDR_W      = 2 * SIDE_W;
    localparam int CELLS       = MAX_SIDE * MAX_SIDE;
    localparam int LBL_W       = 10;
    localparam int SIZE_W      = 11;
    localparam int REG_CNT     = (CELLS + 1) / 2;
    localparam int REG_AW      = $clog2(REG_CNT);
    localparam int SP_W        = ADDR_W + 1;

    localparam logic [LBL_W-1:0] LBL_BG      = LBL_W'(0);
    localparam logic [LBL_W-1:0] LBL_FG      = LBL_W'(1);
    localparam logic [LBL_W-1:0] FIRST_LABEL = LBL_W'(2);

    typedef struct packed {
        logic [CFG_W-1:0] side;
    } t_job;

    typedef struct packed {
        logic busy;
        logic done;
    } t_back_stat;
endpackage

// ===== rtl/core/largest_region_after_one_fill.sv =====
// Top level: largest 4-connected region reachable by filling one background pixel
//
//  channel        | direction | handshake        | payload
//  side_length    | in        | valid / ready    | 6-bit side, any write restarts the image
//  pixel          | in        | valid / stall    | 1 bit, row-major
//  largest_size   | out       | valid / stall    | 11 bits, one beat per image
//
//  Pixels load into the shared label store; the pixel channel then stalls while the back end
//  works on that store: a scan reads every pixel, a stack walk labels each foreground
//  region, and a fill pass checks the neighbours of each background pixel.
//  Reset is synchronous, active low; no store clearing is needed.
//  A stalled result holds the back end in its done state; pixels stay stalled meanwhile.
module largest_region_after_one_fill (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [lrf_pkg::CFG_W-1:0]   i_side_length,
    input  logic                        i_side_length_valid,
    output logic                        o_side_length_ready,
    input  logic                        i_pixel,
    input  logic                        i_pixel_valid,
    output logic                        o_pixel_stall,
    output logic [lrf_pkg::SIZE_W-1:0]  o_largest_size,
    output logic                        o_largest_size_valid,
    input  logic                        i_largest_size_stall
);
    import lrf_pkg::*;

    t_back_stat        stat;
    t_job              push_job, q_job;
    logic              push, q_full, q_valid, q_pop;
    logic              f_we, b_we;
    logic [ADDR_W-1:0] f_waddr, b_waddr, raddr;
    logic [LBL_W-1:0]  f_wdata, b_wdata, rdata;

    assign o_side_length_ready = 1'b1;

    lrf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_side_length(i_side_length), .i_side_length_valid(i_side_length_valid),
        .i_pixel(i_pixel), .i_pixel_valid(i_pixel_valid), .o_pixel_stall(o_pixel_stall),
        .i_stat(stat), .i_q_full(q_full), .o_push(push), .o_job(push_job),
        .o_we(f_we), .o_waddr(f_waddr), .o_wdata(f_wdata)
    );

    lrf_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(push_job),
        .o_full(q_full), .o_valid(q_valid), .o_job(q_job), .i_pop(q_pop)
    );

    lrf_ram #(.WIDTH(LBL_W), .DEPTH(CELLS)) u_labels (
        .i_clk(i_clk), .i_we(f_we || b_we),
        .i_waddr(stat.busy ? b_waddr : f_waddr),
        .i_wdata(stat.busy ? b_wdata : f_wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    lrf_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_job(q_job),
        .o_q_pop(q_pop), .o_stat(stat),
        .o_lbl_we(b_we), .o_lbl_waddr(b_waddr), .o_lbl_wdata(b_wdata),
        .o_lbl_raddr(raddr), .i_lbl_rdata(rdata),
        .o_largest_size(o_largest_size), .o_largest_size_valid(o_largest_size_valid),
        .i_largest_size_stall(i_largest_size_stall)
    );
endmodule

// ===== rtl/core/lrf_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module lrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/lrf_queue.sv =====
// Two-entry job queue between the pixel front end and the labelling back end
module lrf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lrf_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output lrf_pkg::t_job o_job,
    input  logic          i_pop
);
    import lrf_pkg::*;

    t_job       r_slot [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_job;
        end
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_slot[r_rptr];

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid)) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
`endif
endmodule

// ===== rtl/core/lrf_front.sv =====
// Pixel front end: side register, pixel store loading and job hand-off
module lrf_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [lrf_pkg::CFG_W-1:0]   i_side_length,
    input  logic                        i_side_length_valid,
    input  logic                        i_pixel,
    input  logic                        i_pixel_valid,
    output logic                        o_pixel_stall,
    input  lrf_pkg::t_back_stat         i_stat,
    input  logic                        i_q_full,
    output logic                        o_push,
    output lrf_pkg::t_job               o_job,
    output logic                        o_we,
    output logic [lrf_pkg::ADDR_W-1:0]  o_waddr,
    output logic [lrf_pkg::LBL_W-1:0]   o_wdata
);
    import lrf_pkg::*;

    logic [CFG_W-1:0]  r_side;
    logic [SIDE_W-1:0] r_row, r_col;
    logic              r_wait;
    logic [CFG_W-1:0]  side_n, side_m1;
    logic              accept, row_end, img_end;

    always_comb begin
        side_n = r_side;
        if (r_side == '0) side_n = CFG_W'(1);
        if (r_side > CFG_W'(MAX_SIDE)) side_n = CFG_W'(MAX_SIDE);
        side_m1 = side_n - CFG_W'(1);
    end

    assign o_pixel_stall = r_wait || i_q_full;
    assign accept  = i_pixel_valid && !o_pixel_stall;
    assign row_end = (CFG_W'(r_col) == side_m1);
    assign img_end = row_end && (CFG_W'(r_row) == side_m1);

    assign o_we     = accept;
    assign o_waddr  = {r_row, r_col};
    assign o_wdata  = LBL_W'(i_pixel);
    assign o_push   = accept && img_end;
    assign o_job.side = side_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= CFG_W'(MAX_SIDE);
            r_row  <= '0;
            r_col  <= '0;
            r_wait <= 1'b0;
        end else begin
            if (i_side_length_valid) begin
                r_side <= i_side_length;
                r_row  <= '0;
                r_col  <= '0;
            end else if (accept) begin
                if (img_end) begin
                    r_row  <= '0;
                    r_col  <= '0;
                    r_wait <= 1'b1;
                end else if (row_end) begin
                    r_col <= '0;
                    r_row <= r_row + SIDE_W'(1);
                end else begin
                    r_col <= r_col + SIDE_W'(1);
                end
            end
            if (i_stat.done) r_wait <= 1'b0;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.busy |-> !accept) else $error("pixel loaded while back end busy");
    a_push_sets_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_wait) else $error("wait flag not set after image hand-off");
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CFG_W'(r_col) < CFG_W'(MAX_SIDE) && CFG_W'(r_row) < CFG_W'(MAX_SIDE))
        else $error("pixel position out of range");
`endif
endmodule

// ===== rtl/core/lrf_back.sv =====
// Labelling back end: stack-walk region labelling, fill pass and result register
module lrf_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  lrf_pkg::t_job               i_job,
    output logic                        o_q_pop,
    output lrf_pkg::t_back_stat         o_stat,
    output logic                        o_lbl_we,
    output logic [lrf_pkg::ADDR_W-1:0]  o_lbl_waddr,
    output logic [lrf_pkg::LBL_W-1:0]   o_lbl_wdata,
    output logic [lrf_pkg::ADDR_W-1:0]  o_lbl_raddr,
    input  logic [lrf_pkg::LBL_W-1:0]   i_lbl_rdata,
    output logic [lrf_pkg::SIZE_W-1:0]  o_largest_size,
    output logic                        o_largest_size_valid,
    input  logic                        i_largest_size_stall
);
    import lrf_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_SCAN_RD   = 13'b0000000000010,
        S_SCAN_CHK  = 13'b0000000000100,
        S_POP       = 13'b0000000001000,
        S_POP_WAIT  = 13'b0000000010000,
        S_NB_RD     = 13'b0000000100000,
        S_NB_CHK    = 13'b0000001000000,
        S_FILL_RD   = 13'b0000010000000,
        S_FILL_CHK  = 13'b0000100000000,
        S_FILL_NRD  = 13'b0001000000000,
        S_FILL_NCHK = 13'b0010000000000,
        S_FILL_ADD  = 13'b0100000000000,
        S_DONE      = 13'b1000000000000
    } t_state;

    t_state            r_state;
    logic [CFG_W-1:0]  r_n;
    logic [SIDE_W-1:0] r_sr, r_sc, r_cr, r_cc;
    logic [SP_W-1:0]   r_sp;
    logic [SIZE_W-1:0] r_cnt, r_best, r_total;
    logic [LBL_W-1:0]  r_lbl;
    logic [LBL_W-1:0]  r_seen [3];
    logic [1:0]        r_nseen, r_k;
    logic [ADDR_W-1:0] r_qaddr;
    logic              r_out_valid;
    logic [SIZE_W-1:0] r_out;

    logic              stk_we;
    logic [ADDR_W-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;
    logic              sz_we;
    logic [REG_AW-1:0] sz_waddr, sz_raddr;
    logic [SIZE_W-1:0] sz_wdata, sz_rdata;

    lrf_ram #(.WIDTH(ADDR_W), .DEPTH(CELLS)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    lrf_ram #(.WIDTH(SIZE_W), .DEPTH(REG_CNT)) u_sizes (
        .i_clk(i_clk), .i_we(sz_we), .i_waddr(sz_waddr), .i_wdata(sz_wdata),
        .i_raddr(sz_raddr), .o_rdata(sz_rdata)
    );

    logic              nb_ok;
    logic [SIDE_W-1:0] nb_r, nb_c;
    logic [ADDR_W-1:0] nb_addr;
    logic              scan_last, dup;
    logic [LBL_W-1:0]  lbl_m2;

    always_comb begin
        nb_r = r_cr;
        nb_c = r_cc;
        unique case (r_k)
            2'd0: begin
                nb_ok = (r_cr != '0);
                nb_r  = r_cr - SIDE_W'(1);
            end
            2'd1: begin
                nb_ok = (CFG_W'(r_cr) + CFG_W'(1)) < r_n;
                nb_r  = r_cr + SIDE_W'(1);
            end
            2'd2: begin
                nb_ok = (r_cc != '0);
                nb_c  = r_cc - SIDE_W'(1);
            end
            default: begin
                nb_ok = (CFG_W'(r_cc) + CFG_W'(1)) < r_n;
                nb_c  = r_cc + SIDE_W'(1);
            end
        endcase
        nb_addr   = {nb_r, nb_c};
        scan_last = (CFG_W'(r_sr) == r_n - CFG_W'(1)) && (CFG_W'(r_sc) == r_n - CFG_W'(1));
        dup = ((r_nseen > 2'd0) && (r_seen[0] == i_lbl_rdata))
           || ((r_nseen > 2'd1) && (r_seen[1] == i_lbl_rdata))
           || ((r_nseen > 2'd2) && (r_seen[2] == i_lbl_rdata));
        lbl_m2 = i_lbl_rdata - FIRST_LABEL;
    end

    always_comb begin
        o_lbl_we    = 1'b0;
        o_lbl_waddr = r_qaddr;
        o_lbl_wdata = r_lbl;
        o_lbl_raddr = {r_sr, r_sc};
        stk_we      = 1'b0;
        stk_waddr   = r_sp[ADDR_W-1:0];
        stk_wdata   = r_qaddr;
        stk_raddr   = r_sp[ADDR_W-1:0] - ADDR_W'(1);
        sz_we       = 1'b0;
        sz_waddr    = REG_AW'(r_lbl - FIRST_LABEL);
        sz_wdata    = r_cnt;
        sz_raddr    = REG_AW'(lbl_m2);
        unique case (r_state)
            S_SCAN_CHK: begin
                o_lbl_waddr = {r_sr, r_sc};
                stk_waddr   = '0;
                stk_wdata   = {r_sr, r_sc};
                if (i_lbl_rdata == LBL_FG) begin
                    o_lbl_we = 1'b1;
                    stk_we   = 1'b1;
                end
            end
            S_POP: sz_we = (r_sp == '0);
            S_NB_RD, S_FILL_NRD: o_lbl_raddr = nb_addr;
            S_NB_CHK: begin
                if (i_lbl_rdata == LBL_FG) begin
                    o_lbl_we = 1'b1;
                    stk_we   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = (r_state == S_DONE) && !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sp        <= '0;
        end else begin
            if (r_out_valid && !i_largest_size_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_n     <= i_job.side;
                        r_sr    <= '0;
                        r_sc    <= '0;
                        r_lbl   <= FIRST_LABEL;
                        r_best  <= '0;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN_CHK;
                S_SCAN_CHK, S_POP: begin
                    if (r_state == S_SCAN_CHK && i_lbl_rdata == LBL_FG) begin
                        r_sp    <= SP_W'(1);
                        r_cnt   <= '0;
                        r_state <= S_POP;
                    end else if (r_state == S_POP && r_sp != '0) begin
                        r_sp    <= r_sp - SP_W'(1);
                        r_state <= S_POP_WAIT;
                    end else begin
                        if (r_state == S_POP) begin
                            if (r_cnt > r_best) r_best <= r_cnt;
                            r_lbl <= r_lbl + LBL_W'(1);
                        end
                        if (scan_last) begin
                            r_sr    <= '0;
                            r_sc    <= '0;
                            r_state <= S_FILL_RD;
                        end else begin
                            if (CFG_W'(r_sc) == r_n - CFG_W'(1)) begin
                                r_sc <= '0;
                                r_sr <= r_sr + SIDE_W'(1);
                            end else begin
                                r_sc <= r_sc + SIDE_W'(1);
                            end
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_POP_WAIT: begin
                    r_cr    <= stk_rdata[ADDR_W-1:SIDE_W];
                    r_cc    <= stk_rdata[SIDE_W-1:0];
                    r_cnt   <= r_cnt + SIZE_W'(1);
                    r_k     <= '0;
                    r_state <= S_NB_RD;
                end
                S_NB_RD: begin
                    r_qaddr <= nb_addr;
                    if (nb_ok) begin
                        r_state <= S_NB_CHK;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= (r_k == 2'd3) ? S_POP : S_NB_RD;
                    end
                end
                S_NB_CHK: begin
                    if (i_lbl_rdata == LBL_FG) r_sp <= r_sp + SP_W'(1);
                    r_k     <= r_k + 2'd1;
                    r_state <= (r_k == 2'd3) ? S_POP : S_NB_RD;
                end
                S_FILL_RD: r_state <= S_FILL_CHK;
                S_FILL_CHK, S_FILL_NRD, S_FILL_NCHK, S_FILL_ADD: begin
                    if (r_state == S_FILL_CHK && i_lbl_rdata == LBL_BG) begin
                        r_cr    <= r_sr;
                        r_cc    <= r_sc;
                        r_k     <= '0;
                        r_total <= SIZE_W'(1);
                        r_nseen <= '0;
                        r_state <= S_FILL_NRD;
                    end else if (r_state == S_FILL_NRD && nb_ok) begin
                        r_state <= S_FILL_NCHK;
                    end else if (r_state == S_FILL_NCHK && i_lbl_rdata != LBL_BG && !dup) begin
                        r_seen[r_nseen] <= i_lbl_rdata;
                        r_nseen         <= r_nseen + 2'd1;
                        r_state         <= S_FILL_ADD;
                    end else if (r_state != S_FILL_CHK && r_k != 2'd3) begin
                        if (r_state == S_FILL_ADD) r_total <= r_total + sz_rdata;
                        r_k     <= r_k + 2'd1;
                        r_state <= S_FILL_NRD;
                    end else begin
                        if (r_state == S_FILL_ADD) begin
                            if (r_total + sz_rdata > r_best) r_best <= r_total + sz_rdata;
                        end else if (r_state != S_FILL_CHK) begin
                            if (r_total > r_best) r_best <= r_total;
                        end
                        if (scan_last) begin
                            r_state <= S_DONE;
                        end else begin
                            if (CFG_W'(r_sc) == r_n - CFG_W'(1)) begin
                                r_sc <= '0;
                                r_sr <= r_sr + SIDE_W'(1);
                            end else begin
                                r_sc <= r_sc + SIDE_W'(1);
                            end
                            r_state <= S_FILL_RD;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid) begin
                        r_out       <= r_best;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_largest_size       = r_out;
    assign o_largest_size_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_sp <= SP_W'(CELLS))) else $error("walk stack overrun");
    a_lbl_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_lbl <= FIRST_LABEL + LBL_W'(REG_CNT)))
        else $error("region label out of range");
    a_result_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_out != '0)) else $error("zero result emitted");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.done |=> (r_state == S_IDLE)) else $error("back end not idle after result");
`endif
endmodule

// ===== tb/sv/tb.sv =====
// Testbench for largest_region_after_one_fill: predicts each image's answer and checks it
`timescale 1ns / 100ps

module tb;
    import lrf_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic [CFG_W-1:0]  i_side_length = '0;
    logic              i_side_length_valid = 1'b0;
    logic              o_side_length_ready;
    logic              i_pixel = 1'b0;
    logic              i_pixel_valid = 1'b0;
    logic              o_pixel_stall;
    logic [SIZE_W-1:0] o_largest_size;
    logic              o_largest_size_valid;
    logic              i_largest_size_stall = 1'b0;

    largest_region_after_one_fill uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    int                side_reg;
    logic              img[CELLS];
    int                img_fill;
    logic [SIZE_W-1:0] size_q[$];
    int                n_err;
    bit                rx_stall_on = 1'b1;
    int                rx_wait = 0;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        n_err++;
    endtask

    function automatic int side_used();
        if (side_reg < 1) return 1;
        if (side_reg > MAX_SIDE) return MAX_SIDE;
        return side_reg;
    endfunction

    function automatic int best_fill(input int n);
        int lbl[CELLS];
        int sz[CELLS];
        int stk[CELLS];
        int sp, nl, best, p, q, r, c, k, nr, nc, tot, cnt;
        int seen[4];
        int ns;
        bit dup;
        int dr[4] = '{-1, 1, 0, 0};
        int dc[4] = '{0, 0, -1, 1};
        nl = 2;
        best = 0;
        for (p = 0; p < n * n; p++) lbl[p] = img[p] ? 1 : 0;
        for (p = 0; p < n * n; p++) begin
            if (lbl[p] == 1) begin
                sp = 0; cnt = 0;
                lbl[p] = nl;
                stk[sp++] = p;
                while (sp > 0) begin
                    q = stk[--sp];
                    r = q / n; c = q % n;
                    cnt++;
                    for (k = 0; k < 4; k++) begin
                        nr = r + dr[k]; nc = c + dc[k];
                        if (nr < 0 || nc < 0 || nr >= n || nc >= n) continue;
                        if (lbl[nr*n+nc] == 1) begin
                            lbl[nr*n+nc] = nl;
                            stk[sp++] = nr * n + nc;
                        end
                    end
                end
                sz[nl] = cnt;
                if (cnt > best) best = cnt;
                nl++;
            end
        end
        for (p = 0; p < n * n; p++) begin
            if (lbl[p] != 0) continue;
            r = p / n; c = p % n;
            tot = 1; ns = 0;
            for (k = 0; k < 4; k++) begin
                nr = r + dr[k]; nc = c + dc[k];
                if (nr < 0 || nc < 0 || nr >= n || nc >= n) continue;
                q = lbl[nr*n+nc];
                if (q == 0) continue;
                dup = 1'b0;
                for (int j = 0; j < ns; j++) if (seen[j] == q) dup = 1'b1;
                if (dup) continue;
                seen[ns++] = q;
                tot += sz[q];
            end
            if (tot > best) best = tot;
        end
        return best;
    endfunction

    task automatic send_pixel(input logic px);
        int gap;
        int n;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_pixel_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_pixel <= px;
        i_pixel_valid <= 1'b1;
        @(posedge i_clk);
        while (o_pixel_stall) @(posedge i_clk);
        n = side_used();
        img[img_fill++] = px;
        if (img_fill >= n * n) begin
            size_q.push_back(SIZE_W'(best_fill(n)));
            img_fill = 0;
        end
    endtask

    task automatic drain();
        i_pixel_valid <= 1'b0;
        while (size_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_side(input int s);
        drain();
        i_side_length <= CFG_W'(s);
        i_side_length_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_side_length_ready) @(posedge i_clk);
        i_side_length_valid <= 1'b0;
        side_reg = s;
        img_fill = 0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_largest_size_valid) begin
            if (!i_largest_size_stall) begin
                if (size_q.size() == 0)
                    report($sformatf("unexpected result %0d", o_largest_size));
                else if (o_largest_size !== size_q[0]) begin
                    report($sformatf("largest_size got %0d exp %0d",
                                     o_largest_size, size_q[0]));
                    void'(size_q.pop_front());
                end else
                    void'(size_q.pop_front());
                rx_wait = rx_stall_on ? $urandom_range(0, 9) : 0;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
        end
        i_largest_size_stall <= (rx_wait > 0);
    end

    task automatic send_image(input int mode);
        int n;
        n = side_used();
        for (int i = 0; i < n * n; i++) begin
            case (mode)
                0: send_pixel(1'b1);
                1: send_pixel(1'b0);
                2: send_pixel(1'(($urandom_range(0, 9)) < 6));
                default: send_pixel(1'($urandom));
            endcase
        end
    endtask

    task automatic test_extremes();
        write_side(1);
        send_image(0);
        send_image(1);
        write_side(2);
        send_image(0);
        send_image(1);
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b0);
        send_pixel(1'b1);
    endtask

    // a side of zero runs a single-pixel image; a side above the maximum runs a full-size image
    task automatic test_out_of_range();
        write_side(0);
        send_image(3);
        write_side(63);
        send_image(2);
    endtask

    task automatic test_abort_mid_image();
        write_side(4);
        for (int i = 0; i < 7; i++) send_pixel(1'($urandom));
        write_side(3);
        send_image(3);
    endtask

    task automatic test_random();
        int sent;
        int s;
        sent = 0;
        while (sent < 600) begin
            s = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
            write_side(s);
            for (int k = 0; k < 3; k++) begin
                rx_stall_on = ($urandom_range(0, 3) != 0);
                send_image($urandom_range(0, 9) < 7 ? 2 + $urandom_range(0, 1)
                                                    : $urandom_range(0, 1));
                sent += s * s;
                if ($urandom_range(0, 5) == 0) drain();
            end
        end
        rx_stall_on = 1'b1;
    endtask

    initial begin
        side_reg = 32;
        img_fill = 0;
        n_err = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_out_of_range();
        test_abort_mid_image();
        test_random();
        drain();
        if (n_err == 0 && size_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #200ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
